// File: src/lrdg_pkg.sv
// ----------------------------------------------------------------------------
// lrdg_pkg: shared types and constants for the LED ramp dimmer
// Action codes, register indexes, lamp state and the square-law duty table.
// ----------------------------------------------------------------------------
package lrdg_pkg;

  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned DUTY_W    = 8;
  localparam int unsigned RATE_W    = 7;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 7;

  localparam int unsigned LEVEL_MAX = 100;
  localparam int unsigned PWM_MAX   = 255;
  localparam int unsigned DUTY_DEN  = LEVEL_MAX * LEVEL_MAX;
  localparam int unsigned DUTY_TOP  = (1 << DUTY_W) - 1;
  localparam int unsigned LEVEL_LIM = 1 << LEVEL_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK        = 3'd0,
    ACT_SET_ON      = 3'd1,
    ACT_TOGGLE_ON   = 3'd2,
    ACT_SET_LEVEL   = 3'd3,
    ACT_TOGGLE_DIR  = 3'd4,
    ACT_SET_DIR     = 3'd5,
    ACT_SET_DIMMING = 3'd6
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_RATE    = 1'b0,
    REG_CYCLIC_MODE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               on;
    logic               up;
    logic               dimming;
    logic               overrun;
  } lamp_state_t;

  typedef logic [DUTY_W-1:0] duty_lut_t [LEVEL_LIM];

  // Square-law duty per level, saturated to the output range
  function automatic duty_lut_t build_duty_lut();
    duty_lut_t   lut;
    int unsigned prod;
    for (int unsigned i = 0; i < LEVEL_LIM; i++) begin
      prod   = (i * i * PWM_MAX) / DUTY_DEN;
      lut[i] = (prod > DUTY_TOP) ? DUTY_W'(DUTY_TOP) : DUTY_W'(prod);
    end
    return lut;
  endfunction

  localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

// File: src/lrdg_in_if.sv
// ----------------------------------------------------------------------------
// lrdg_in_if: request channel of the LED ramp dimmer
// Valid/ready channel carrying one tick or command.
// ----------------------------------------------------------------------------
interface lrdg_in_if;
  import lrdg_pkg::*;

  logic               valid;
  logic               ready;
  action_t            action;
  logic               flag;
  logic [LEVEL_W-1:0] level_value;

  modport source (output valid, output action, output flag, output level_value,
                  input ready);
  modport sink   (input valid, input action, input flag, input level_value,
                  output ready);
endinterface

// File: src/lrdg_out_if.sv
// ----------------------------------------------------------------------------
// lrdg_out_if: result channel of the LED ramp dimmer
// Valid/ready channel carrying the lamp state after each request.
// ----------------------------------------------------------------------------
interface lrdg_out_if;
  import lrdg_pkg::*;

  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty;
  logic [LEVEL_W-1:0] level_now;
  logic               is_on;
  logic               going_up;
  logic               dimming_active;
  logic               overrun_flag;

  modport source (output valid, output duty, output level_now, output is_on,
                  output going_up, output dimming_active, output overrun_flag,
                  input ready);
  modport sink   (input valid, input duty, input level_now, input is_on,
                  input going_up, input dimming_active, input overrun_flag,
                  output ready);
endinterface

// File: src/led_ramp_dimmer_gamma.sv
// ----------------------------------------------------------------------------
// led_ramp_dimmer_gamma: LED ramp dimmer with square-law duty
// Takes ticks and commands, keeps the lamp state, reports duty and state.
// ----------------------------------------------------------------------------
// Timing: the request is registered in the input register, then the state
// update is registered into the result register.
// Throughput: one request per cycle when not stalled; the state update is a single pass.
// Reset: lamp off, level 0, direction up, dimming off, no overrun;
// dim_rate 5, cyclic_mode 1; both channels empty.
module led_ramp_dimmer_gamma (
  input  logic                             clk,
  input  logic                             rst,
  lrdg_in_if.sink                          in_ch,
  lrdg_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [lrdg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lrdg_pkg::CFG_W-1:0]       cfg_data
);
  import lrdg_pkg::*;

  logic [RATE_W-1:0]  dim_rate;
  logic               cyclic_mode;

  logic               a_valid;
  logic               a_ready;
  action_t            a_action;
  logic               a_flag;
  logic [LEVEL_W-1:0] a_level;

  lamp_state_t        state;
  lamp_state_t        state_next;
  logic               a_fire;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_rate    <= RATE_W'(5);
      cyclic_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIM_RATE:    dim_rate    <= cfg_data[RATE_W-1:0];
        REG_CYCLIC_MODE: cyclic_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Input register: advance whenever the result stage can take its request
  assign a_ready     = !out_ch.valid || out_ch.ready;
  assign a_fire      = a_valid && a_ready;
  assign in_ch.ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_action <= in_ch.action;
      a_flag   <= in_ch.flag;
      a_level  <= in_ch.level_value;
    end
  end

  lrdg_step u_step (
    .cur         (state),
    .action      (a_action),
    .flag        (a_flag),
    .level_value (a_level),
    .dim_rate    (dim_rate),
    .cyclic_mode (cyclic_mode),
    .nxt         (state_next)
  );

  // Lamp state: update once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{level: '0, on: 1'b0, up: 1'b1, dimming: 1'b0, overrun: 1'b0};
    end else if (a_fire) begin
      state <= state_next;
    end
  end

  // Result register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (a_fire) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      out_ch.duty           <= state_next.on ? DUTY_LUT[state_next.level] : '0;
      out_ch.level_now      <= state_next.level;
      out_ch.is_on          <= state_next.on;
      out_ch.going_up       <= state_next.up;
      out_ch.dimming_active <= state_next.dimming;
      out_ch.overrun_flag   <= state_next.overrun;
    end
  end

`ifndef ASSERT_OFF
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    state.level <= LEVEL_W'(LEVEL_MAX))
    else $error("level above maximum");

  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.is_on |-> out_ch.duty == '0)
    else $error("nonzero duty while off");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.level_now == state.level && out_ch.is_on == state.on)
    else $error("result disagrees with lamp state");

  a_stall_freezes_state: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(state))
    else $error("state changed during output stall");

  a_stall_keeps_request: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_ready |=> a_valid)
    else $error("pending request dropped");
`endif

endmodule

// File: src/lrdg_step.sv
// ----------------------------------------------------------------------------
// lrdg_step: next-state logic of the LED ramp dimmer
// Applies one tick or command to the lamp state, including end handling.
// ----------------------------------------------------------------------------
module lrdg_step (
  input  lrdg_pkg::lamp_state_t           cur,
  input  lrdg_pkg::action_t               action,
  input  logic                            flag,
  input  logic [lrdg_pkg::LEVEL_W-1:0]    level_value,
  input  logic [lrdg_pkg::RATE_W-1:0]     dim_rate,
  input  logic                            cyclic_mode,
  output lrdg_pkg::lamp_state_t           nxt
);
  import lrdg_pkg::*;

  logic               run;
  logic [LEVEL_W:0]   up_sum;
  logic               hit_top;
  logic               hit_bottom;
  logic [LEVEL_W-1:0] dn_level;

  // Ramp arithmetic: one add and compare for up, one compare and subtract for down
  assign run        = cur.on && cur.dimming && !cur.overrun;
  assign up_sum     = {1'b0, cur.level} + (LEVEL_W+1)'(dim_rate);
  assign hit_top    = up_sum >= (LEVEL_W+1)'(LEVEL_MAX);
  assign hit_bottom = (LEVEL_W+1)'(cur.level) <= (LEVEL_W+1)'(dim_rate);
  assign dn_level   = cur.level - LEVEL_W'(dim_rate);

  always_comb begin
    nxt = cur;
    case (action)
      ACT_TICK: begin
        if (run) begin
          if (cur.up) begin
            if (hit_top) begin
              nxt.level   = LEVEL_W'(LEVEL_MAX);
              nxt.up      = !cyclic_mode;
              nxt.dimming = cyclic_mode;
              nxt.overrun = !cyclic_mode;
            end else begin
              nxt.level = up_sum[LEVEL_W-1:0];
            end
          end else begin
            // Bottom end also switches the lamp off when not cycling
            if (hit_bottom) begin
              nxt.level   = '0;
              nxt.up      = cyclic_mode;
              nxt.dimming = cyclic_mode;
              nxt.overrun = !cyclic_mode;
              nxt.on      = cyclic_mode;
            end else begin
              nxt.level = dn_level;
            end
          end
        end
      end
      ACT_SET_ON: begin
        nxt.overrun = 1'b0;
        nxt.on      = flag;
      end
      ACT_TOGGLE_ON: begin
        nxt.overrun = 1'b0;
        nxt.on      = !cur.on;
      end
      ACT_SET_LEVEL: begin
        nxt.level = (level_value > LEVEL_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                        : level_value;
      end
      ACT_TOGGLE_DIR: begin
        nxt.overrun = 1'b0;
        nxt.up      = !cur.up;
      end
      ACT_SET_DIR: begin
        nxt.up = flag;
      end
      ACT_SET_DIMMING: begin
        nxt.dimming = flag;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule
